// File: src/mrrc_pkg.sv
package mrrc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 9;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [POS_W-1:0] POS_MAX  = 9'd511;
    localparam logic [POS_W-1:0] MIN_LEN  = 9'd5;

    localparam logic [POS_W-1:0] POS_ADDRESS  = 9'd0;
    localparam logic [POS_W-1:0] POS_FUNCTION = 9'd1;
    localparam logic [POS_W-1:0] POS_COUNT    = 9'd2;
    localparam logic [POS_W-1:0] POS_PAYLOAD  = 9'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_CAPACITY = 2'd2;

    localparam logic [BYTE_W-1:0] RST_SLAVE_ADDRESS    = 8'd1;
    localparam logic [BYTE_W-1:0] RST_FUNCTION_CODE    = 8'd3;
    localparam logic [BYTE_W-1:0] RST_PAYLOAD_CAPACITY = 8'd255;

    // CRC-16/MODBUS, one byte, LSB first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: src/mrrc_if.sv
interface mrrc_rx_if;
    logic                           valid;
    logic                           ready;
    logic [mrrc_pkg::BYTE_W-1:0]    rx_byte;
    logic                           frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrrc_res_if;
    logic                           valid;
    logic                           ready;
    logic [mrrc_pkg::BYTE_W-1:0]    data_byte;
    logic [mrrc_pkg::BYTE_W-1:0]    data_index;
    logic                           data_valid;
    logic                           frame_done;
    logic                           frame_ok;
    logic [mrrc_pkg::BYTE_W-1:0]    payload_count;

    modport source (output valid, output data_byte, output data_index, output data_valid,
                    output frame_done, output frame_ok, output payload_count,
                    input ready);
    modport sink   (input valid, input data_byte, input data_index, input data_valid,
                    input frame_done, input frame_ok, input payload_count,
                    output ready);
endinterface

interface mrrc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mrrc_pkg::CFG_IDX_W-1:0]     index;
    logic [mrrc_pkg::BYTE_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/modbus_read_response_checker.sv
// Modbus RTU read-response checker.
// rx:  one received frame byte per beat, frame_end set on the frame's last byte.
// res: one result beat per rx beat. data_valid/data_byte/data_index flag payload
//      bytes as they pass (tentative); on the last byte frame_done is set and
//      frame_ok/payload_count report the verdict. Keep payload only on frame_ok.
// cfg: register writes (0 slave address, 1 function code, 2 payload capacity),
//      always ready; write only while no result is outstanding.
// The result of a byte is registered and is on res in the cycle after its rx beat.
// Throughput: one byte per cycle while res is not stalled; the CRC update is an unrolled 8-bit step
// between the frame state registers and the result register.
// A full result register still takes a new byte in the cycle res drains it;
// when res stalls, rx.ready drops until the result is taken.
// Reset: registers return to address 1, function 3, capacity 255, the frame
// state to start of frame, and the result register empties.
// Frames longer than 511 bytes saturate the byte counter and always fail.
module modbus_read_response_checker
(
    input  logic                clk,
    input  logic                rst_n,
    mrrc_rx_if.sink             rx,
    mrrc_res_if.source          res,
    mrrc_cfg_if.sink            cfg
);

    logic [mrrc_pkg::BYTE_W-1:0]    slave_address_reg;
    logic [mrrc_pkg::BYTE_W-1:0]    function_code_reg;
    logic [mrrc_pkg::BYTE_W-1:0]    payload_capacity_reg;

    logic [mrrc_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [mrrc_pkg::CRC_W-1:0]     crc_reg, crc_next;
    logic                           hdr_reg, hdr_next;
    logic [mrrc_pkg::BYTE_W-1:0]    count_reg, count_next;

    logic                           out_valid_reg;
    logic [mrrc_pkg::BYTE_W-1:0]    data_byte_reg, data_byte_next;
    logic [mrrc_pkg::BYTE_W-1:0]    data_index_reg, data_index_next;
    logic                           data_valid_reg, data_valid_next;
    logic                           frame_done_reg;
    logic                           frame_ok_reg, frame_ok_next;
    logic [mrrc_pkg::BYTE_W-1:0]    plen_reg, plen_next;

    logic                           rx_fire;
    logic [mrrc_pkg::POS_W-1:0]     len;
    logic [mrrc_pkg::POS_W-1:0]     pay_off;

    assign rx.ready  = !out_valid_reg || res.ready;
    assign rx_fire   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg    <= mrrc_pkg::RST_SLAVE_ADDRESS;
            function_code_reg    <= mrrc_pkg::RST_FUNCTION_CODE;
            payload_capacity_reg <= mrrc_pkg::RST_PAYLOAD_CAPACITY;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mrrc_pkg::CFG_SLAVE_ADDRESS:    slave_address_reg    <= cfg.data;
                mrrc_pkg::CFG_FUNCTION_CODE:    function_code_reg    <= cfg.data;
                mrrc_pkg::CFG_PAYLOAD_CAPACITY: payload_capacity_reg <= cfg.data;
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        hdr_next   = hdr_reg;
        count_next = count_reg;
        case (pos_reg)
            mrrc_pkg::POS_ADDRESS:  hdr_next   = hdr_reg && (rx.rx_byte == slave_address_reg);
            mrrc_pkg::POS_FUNCTION: hdr_next   = hdr_reg && (rx.rx_byte == function_code_reg);
            mrrc_pkg::POS_COUNT:    count_next = rx.rx_byte;
            default:                ;
        endcase

        pay_off         = pos_reg - mrrc_pkg::POS_PAYLOAD;
        data_valid_next = (pos_reg >= mrrc_pkg::POS_PAYLOAD) &&
                          (pay_off < {1'b0, count_reg});
        data_byte_next  = data_valid_next ? rx.rx_byte : '0;
        data_index_next = data_valid_next ? pay_off[mrrc_pkg::BYTE_W-1:0] : '0;

        crc_next = mrrc_pkg::crc16_byte(crc_reg, rx.rx_byte);
        len      = (pos_reg == mrrc_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;

        frame_ok_next = rx.frame_end && (len >= mrrc_pkg::MIN_LEN) && hdr_next &&
                        ({1'b0, count_next} == len - mrrc_pkg::MIN_LEN) &&
                        (count_next <= payload_capacity_reg) && (crc_next == '0);
        plen_next     = frame_ok_next ? count_next : '0;

        pos_next = len;
        if (rx.frame_end)
        begin
            pos_next   = '0;
            crc_next   = mrrc_pkg::CRC_INIT;
            hdr_next   = 1'b1;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= mrrc_pkg::CRC_INIT;
            hdr_reg   <= 1'b1;
            count_reg <= '0;
        end
        else if (rx_fire)
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            hdr_reg   <= hdr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rx_fire)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // hold the result while res stalls; rx.ready keeps new bytes out
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            data_byte_reg  <= data_byte_next;
            data_index_reg <= data_index_next;
            data_valid_reg <= data_valid_next;
            frame_done_reg <= rx.frame_end;
            frame_ok_reg   <= frame_ok_next;
            plen_reg       <= plen_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.data_byte      = data_byte_reg;
    assign res.data_index     = data_index_reg;
    assign res.data_valid     = data_valid_reg;
    assign res.frame_done     = frame_done_reg;
    assign res.frame_ok       = frame_ok_reg;
    assign res.payload_count  = plen_reg;

endmodule

// File: src/mrrc_checker.sv
module mrrc_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rx_valid,
    input  logic                            rx_ready,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  logic [mrrc_pkg::BYTE_W-1:0]     res_data_byte,
    input  logic [mrrc_pkg::BYTE_W-1:0]     res_data_index,
    input  logic                            res_data_valid,
    input  logic                            res_frame_done,
    input  logic                            res_frame_ok,
    input  logic [mrrc_pkg::BYTE_W-1:0]     res_payload_count
);

    // every accepted byte yields a result beat in the next cycle
    a_rx_to_res: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_valid && rx_ready) |=> res_valid)
        else $error("accepted byte produced no result");

    // a stalled result stays valid
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped while stalled");

    a_ok_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_frame_ok) |-> res_frame_done)
        else $error("frame_ok without frame_done");

    a_plen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_frame_ok) |-> (res_payload_count == '0))
        else $error("payload_count set on failed frame");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data_valid) |-> (res_data_byte == '0 && res_data_index == '0))
        else $error("payload fields set outside payload span");

endmodule

bind modbus_read_response_checker mrrc_checker u_mrrc_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .rx_valid           (rx.valid),
    .rx_ready           (rx.ready),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_data_byte      (res.data_byte),
    .res_data_index     (res.data_index),
    .res_data_valid     (res.data_valid),
    .res_frame_done     (res.frame_done),
    .res_frame_ok       (res.frame_ok),
    .res_payload_count  (res.payload_count)
);

// File: test/mrrc_result_checker.sv
`timescale 1ns / 1ps

module mrrc_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    mrrc_rx_if          rx,
    mrrc_res_if         res,
    mrrc_cfg_if         cfg,
    output int unsigned fail_count,
    output int unsigned pending
);

    typedef struct packed {
        logic [mrrc_pkg::BYTE_W-1:0] data_byte;
        logic [mrrc_pkg::BYTE_W-1:0] data_index;
        logic                        data_valid;
        logic                        frame_done;
        logic                        frame_ok;
        logic [mrrc_pkg::BYTE_W-1:0] payload_count;
    } beat_result_t;

    beat_result_t       expected_results[$];
    beat_result_t       predicted;

    // register copies
    logic [mrrc_pkg::BYTE_W-1:0]  slave_addr;
    logic [mrrc_pkg::BYTE_W-1:0]  func_code;
    logic [mrrc_pkg::BYTE_W-1:0]  capacity;

    // frame state
    logic [mrrc_pkg::POS_W-1:0]   frame_pos;
    logic [mrrc_pkg::CRC_W-1:0]   running_crc;
    logic                         hdr_ok;
    logic [mrrc_pkg::BYTE_W-1:0]  decl_cnt;

    int unsigned        mismatch_total;

    // bit-serial CRC-16/MODBUS, data LSB first
    function automatic logic [mrrc_pkg::CRC_W-1:0] crc_after(
        input logic [mrrc_pkg::CRC_W-1:0] c,
        input logic [mrrc_pkg::BYTE_W-1:0] d);
        logic [mrrc_pkg::CRC_W-1:0] r;
        r = c;
        for (int i = 0; i < mrrc_pkg::BYTE_W; i++)
            r = (r[0] ^ d[i]) ? ((r >> 1) ^ mrrc_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic open_frame();
        frame_pos   = '0;
        running_crc = mrrc_pkg::CRC_INIT;
        hdr_ok      = 1'b1;
        decl_cnt    = '0;
    endtask

    task automatic predict_beat(input logic [mrrc_pkg::BYTE_W-1:0] b, input logic last,
                                output beat_result_t r);
        logic [mrrc_pkg::POS_W-1:0] at;
        logic [mrrc_pkg::POS_W-1:0] idx;
        at = frame_pos;
        r  = '0;
        if (at == mrrc_pkg::POS_ADDRESS)
            hdr_ok = hdr_ok && (b == slave_addr);
        else if (at == mrrc_pkg::POS_FUNCTION)
            hdr_ok = hdr_ok && (b == func_code);
        else if (at == mrrc_pkg::POS_COUNT)
            decl_cnt = b;

        // payload span follows the declared count right away
        if (at >= mrrc_pkg::POS_PAYLOAD && (at - mrrc_pkg::POS_PAYLOAD) < {1'b0, decl_cnt})
        begin
            idx          = at - mrrc_pkg::POS_PAYLOAD;
            r.data_valid = 1'b1;
            r.data_byte  = b;
            r.data_index = idx[mrrc_pkg::BYTE_W-1:0];
        end

        running_crc = crc_after(running_crc, b);
        if (frame_pos != mrrc_pkg::POS_MAX)
            frame_pos = frame_pos + 1'b1;

        if (last)
        begin
            r.frame_done = 1'b1;
            // zero residue over data plus received CRC means the CRC matched
            if (frame_pos >= mrrc_pkg::MIN_LEN && hdr_ok
                && {1'b0, decl_cnt} == frame_pos - mrrc_pkg::MIN_LEN
                && decl_cnt <= capacity && running_crc == '0)
            begin
                r.frame_ok      = 1'b1;
                r.payload_count = decl_cnt;
            end
            open_frame();
        end
    endtask

    task automatic compare_field(input string name,
                                 input logic [mrrc_pkg::BYTE_W-1:0] want,
                                 input logic [mrrc_pkg::BYTE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d actual %0d", name, want, got);
            mismatch_total++;
        end
    endtask

    task automatic check_result();
        beat_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result beat with no byte pending");
            mismatch_total++;
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("data_byte", want.data_byte, res.data_byte);
            compare_field("data_index", want.data_index, res.data_index);
            compare_field("data_valid", want.data_valid, res.data_valid);
            compare_field("frame_done", want.frame_done, res.frame_done);
            compare_field("frame_ok", want.frame_ok, res.frame_ok);
            compare_field("payload_count", want.payload_count, res.payload_count);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr = mrrc_pkg::RST_SLAVE_ADDRESS;
            func_code  = mrrc_pkg::RST_FUNCTION_CODE;
            capacity   = mrrc_pkg::RST_PAYLOAD_CAPACITY;
            open_frame();
            expected_results.delete();
            mismatch_total = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
                check_result();

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    mrrc_pkg::CFG_SLAVE_ADDRESS:    slave_addr = cfg.data;
                    mrrc_pkg::CFG_FUNCTION_CODE:    func_code  = cfg.data;
                    mrrc_pkg::CFG_PAYLOAD_CAPACITY: capacity   = cfg.data;
                    default: ;
                endcase
            end

            if (rx.valid && rx.ready)
            begin
                predict_beat(rx.rx_byte, rx.frame_end, predicted);
                expected_results.push_back(predicted);
            end

            fail_count <= mismatch_total;
            pending    <= expected_results.size();
        end
    end

endmodule

// File: test/tb_modbus_read_response_checker.sv
`timescale 1ns / 1ps

module tb_modbus_read_response_checker;

    typedef logic [mrrc_pkg::BYTE_W-1:0] byte_t;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned NUM_PHASES     = 8;
    localparam int unsigned PHASE_BYTES    = 30;
    // index past the last register, must be ignored
    localparam logic [mrrc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    int unsigned        fail_count;
    int unsigned        pending;
    int unsigned        gap_pct;
    int unsigned        stall_pct;
    int unsigned        quiet_cycles;
    int unsigned        bytes_sent;
    byte_t              addr_now;
    byte_t              func_now;
    byte_t              cap_now;
    byte_t              frame_bytes[$];

    mrrc_rx_if  rx();
    mrrc_res_if res();
    mrrc_cfg_if cfg();

    modbus_read_response_checker dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res),
        .cfg   (cfg)
    );

    mrrc_result_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .res        (res),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (rx.valid && rx.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // append CRC-16/MODBUS of the frame, low byte first
    task automatic seal_frame();
        logic [mrrc_pkg::CRC_W-1:0] c;
        c = mrrc_pkg::CRC_INIT;
        foreach (frame_bytes[i])
        begin
            c = c ^ {8'd0, frame_bytes[i]};
            repeat (mrrc_pkg::BYTE_W)
                c = c[0] ? ((c >> 1) ^ mrrc_pkg::CRC_POLY) : (c >> 1);
        end
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endtask

    task automatic send_beat(input byte_t b, input logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
        end
        rx.valid     <= 1'b1;
        rx.rx_byte   <= b;
        rx.frame_end <= last;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // send the next n bytes; frame_end goes on the frame's final byte
    task automatic send_bytes(input int unsigned n);
        byte_t b;
        repeat (n)
        begin
            b = frame_bytes.pop_front();
            send_beat(b, frame_bytes.size() == 0);
        end
    endtask

    task automatic drain();
        rx.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [mrrc_pkg::CFG_IDX_W-1:0] idx, input byte_t val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    // mostly well-formed responses, the rest damaged in one way or pure noise
    task automatic make_random_frame();
        int unsigned       kind;
        int unsigned       roll;
        int unsigned       cut;
        int                decl;
        byte_t             a;
        byte_t             f;
        byte_t             d;
        kind = $urandom_range(99);
        roll = $urandom_range(99);
        a    = addr_now;
        f    = func_now;
        if (roll < 80)
            decl = $urandom_range(12);
        else if (roll < 98 && cap_now <= 32)
        begin
            // straddle the capacity limit
            decl = int'(cap_now) + int'($urandom_range(2)) - 1;
            if (decl < 0)
                decl = 0;
        end
        else if (roll < 98)
            decl = $urandom_range(20);
        else
            decl = $urandom_range(255);
        d = decl[mrrc_pkg::BYTE_W-1:0];

        if (kind >= 94)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 8))
                frame_bytes.push_back(byte_t'($urandom_range(255)));
        end
        else
        begin
            if (kind >= 60 && kind < 66)
                a = a ^ byte_t'($urandom_range(1, 255));
            else if (kind >= 66 && kind < 72)
                f = f ^ byte_t'($urandom_range(1, 255));
            else if (kind >= 72 && kind < 78)
                d = d ^ byte_t'($urandom_range(1, 255));
            frame_bytes = {a, f, d};
            repeat (decl)
                frame_bytes.push_back(byte_t'($urandom_range(255)));
            seal_frame();

            if (kind >= 78 && kind < 84)
            begin
                cut = $urandom_range(frame_bytes.size() - 1);
                frame_bytes[cut] = frame_bytes[cut] ^ (8'd1 << $urandom_range(7));
            end
            else if (kind >= 84 && kind < 89)
            begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end
            else if (kind >= 89)
            begin
                repeat ($urandom_range(1, 3))
                    frame_bytes.push_back(byte_t'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        byte_t             new_addr;
        byte_t             new_func;
        byte_t             new_cap;
        int unsigned       goal;
        int unsigned       head;

        rst_n        = 1'b0;
        rx.valid     = 1'b0;
        rx.rx_byte   = '0;
        rx.frame_end = 1'b0;
        cfg.valid    = 1'b0;
        cfg.index    = mrrc_pkg::CFG_SLAVE_ADDRESS;
        cfg.data     = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        bytes_sent   = 0;
        addr_now     = mrrc_pkg::RST_SLAVE_ADDRESS;
        func_now     = mrrc_pkg::RST_FUNCTION_CODE;
        cap_now      = mrrc_pkg::RST_PAYLOAD_CAPACITY;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // shortest passing frame, empty payload
        frame_bytes = {mrrc_pkg::RST_SLAVE_ADDRESS, mrrc_pkg::RST_FUNCTION_CODE, 8'h00};
        seal_frame();
        send_bytes(frame_bytes.size());
        // two payload bytes at the extremes
        frame_bytes = {mrrc_pkg::RST_SLAVE_ADDRESS, mrrc_pkg::RST_FUNCTION_CODE,
                       8'h02, 8'hFF, 8'h00};
        seal_frame();
        send_bytes(frame_bytes.size());
        // one-byte frame
        frame_bytes = {8'hFF};
        send_bytes(frame_bytes.size());
        // four bytes, one short of the minimum
        frame_bytes = {mrrc_pkg::RST_SLAVE_ADDRESS, mrrc_pkg::RST_FUNCTION_CODE,
                       8'h00, 8'hA5};
        send_bytes(frame_bytes.size());
        // right length, bad CRC
        frame_bytes = {mrrc_pkg::RST_SLAVE_ADDRESS, mrrc_pkg::RST_FUNCTION_CODE,
                       8'h00, 8'h00, 8'h00};
        send_bytes(frame_bytes.size());

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // hold a frame open across the register update on odd phases
            if (p % 2 == 1)
            begin
                make_random_frame();
                if (frame_bytes.size() > 1)
                begin
                    head = frame_bytes.size() - 1;
                    if (head > 4)
                        head = 4;
                    send_bytes($urandom_range(1, head));
                end
            end
            drain();

            case (p)
                0:       begin new_addr = 8'd0;   new_func = 8'd3;   new_cap = 8'd255; end
                1:       begin new_addr = 8'd255; new_func = 8'd4;   new_cap = 8'd0;   end
                2:       begin new_addr = byte_t'($urandom_range(255));
                               new_func = 8'd0;   new_cap = 8'd16;  end
                3:       begin new_addr = 8'd17;  new_func = 8'd255; new_cap = 8'd255; end
                4:       begin new_addr = byte_t'($urandom_range(255));
                               new_func = byte_t'($urandom_range(255));
                               new_cap  = 8'd1; end
                5:       begin new_addr = 8'd1;   new_func = 8'd3;
                               new_cap  = byte_t'($urandom_range(255)); end
                6:       begin new_addr = 8'd255;
                               new_func = byte_t'($urandom_range(255));
                               new_cap  = 8'd8; end
                default: begin new_addr = 8'd0;   new_func = 8'd4;   new_cap = 8'd255; end
            endcase
            write_reg(mrrc_pkg::CFG_SLAVE_ADDRESS, new_addr);
            write_reg(mrrc_pkg::CFG_FUNCTION_CODE, new_func);
            write_reg(mrrc_pkg::CFG_PAYLOAD_CAPACITY, new_cap);
            write_reg(CFG_UNUSED, byte_t'($urandom_range(255)));
            cfg.valid <= 1'b0;
            addr_now = new_addr;
            func_now = new_func;
            cap_now  = new_cap;

            case (p % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 54; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 54; end
                default: begin gap_pct = 25; stall_pct = 25; end
            endcase

            // finish the frame left open, if any
            send_bytes(frame_bytes.size());

            if (p == 0)
            begin
                // run past the byte counter's saturation point
                frame_bytes = {addr_now, func_now, 8'hFF};
                repeat (512)
                    frame_bytes.push_back(byte_t'($urandom_range(255)));
                seal_frame();
                send_bytes(frame_bytes.size());
            end
            else if (p == 3)
            begin
                // largest payload that can pass
                frame_bytes = {addr_now, func_now, 8'hFF};
                repeat (255)
                    frame_bytes.push_back(byte_t'($urandom_range(255)));
                seal_frame();
                send_bytes(frame_bytes.size());
            end

            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
            begin
                make_random_frame();
                send_bytes(frame_bytes.size());
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: modbus_read_response_checker.f
src/mrrc_pkg.sv
src/mrrc_if.sv
src/modbus_read_response_checker.sv
src/mrrc_checker.sv
test/mrrc_result_checker.sv
test/tb_modbus_read_response_checker.sv
